### rtl/core/qtrd_pkg.sv
// Shared types and constants for the quadtree region decoder.
// Used by quadtree_region_decoder and qtrd_quadrant; no dependencies.
`default_nettype none

package qtrd_pkg;

    localparam int DIM_W    = 13;
    localparam int OUT_XY_W = 12;
    localparam int COLOR_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 3;
    localparam int NEXT_W   = 3;
    localparam int OUT_TDATA_W = 88;

    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [BYTE_W-1:0] TAG_BRANCH = 8'd0;
    localparam logic [BYTE_W-1:0] TAG_LEAF   = 8'd1;

    localparam logic [CNT_W-1:0] CNT_TAG    = 3'd0;
    localparam logic [CNT_W-1:0] CNT_BYTE1  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_BYTE2  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_BYTE3  = 3'd3;
    localparam logic [CNT_W-1:0] CNT_BYTE4  = 3'd4;

    localparam logic [1:0] QUAD_NW = 2'd0;
    localparam logic [NEXT_W-1:0] NEXT_FIRST = 3'd1;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_region;

    typedef struct packed {
        t_region             parent;
        logic [NEXT_W-1:0]   next;
    } t_frame;

    typedef struct packed {
        t_region              region;
        logic [COLOR_W-1:0]   color;
        logic                 done;
        logic                 status;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/quadtree_region_decoder.sv
// Top level of the quadtree region decoder: sequencer, level stack and output register.
// Depends on qtrd_pkg and qtrd_quadrant.
//
// Channel   Direction  Width  Contents
// s_axis    in         8      stream byte (tag or color byte)
// m_axis    out        88     rectangle x, y, width, height, color; tlast done; tuser status
// cfg       in         13     image width (index 0), image height (index 1)
//
// Leaf tags and the first three color bytes are taken in S_IDLE; a branch tag also passes
// through S_SPLIT, where the shared quadrant unit computes the first child.
// A bad tag goes to S_EMIT and waits there on m_axis for the previous result.
// The last color byte goes through S_UNWIND, which pops finished levels one per cycle
// and takes the next sibling from the same quadrant unit, then S_EMIT, which waits on m_axis.
// Reset is synchronous and clears the sequencer, stack level and output valid.
`default_nettype none

module quadtree_region_decoder #(
    parameter int MAX_DIM     = 4096,
    parameter int STACK_DEPTH = 13
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [11:0] rect_x, [23:12] rect_y, [36:24] rect_width, [49:37] rect_height,
    // [81:50] rect_color, [87:82] zero
    output logic [87:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // tree_done
    output logic             m_axis_tuser,   // [0] status
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [qtrd_pkg::DIM_W-1:0] DIM_LIMIT =
        (MAX_DIM > 8191) ? 13'h1FFF : 13'(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SPLIT  = 4'b0010,
        S_UNWIND = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [LVL_W-1:0]               r_level, n_level;
    logic [qtrd_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [23:0]                    r_acc, n_acc;
    logic                           r_err, n_err;
    qtrd_pkg::t_region              r_cur, n_cur;
    qtrd_pkg::t_result              r_res, n_res;
    qtrd_pkg::t_result              r_out, n_out;
    logic                           r_out_valid, n_out_valid;
    logic [qtrd_pkg::DIM_W-1:0]     r_img_w, r_img_h;
    qtrd_pkg::t_frame               r_stack [STACK_DEPTH];

    logic                           st_we;
    logic [IDX_W-1:0]               st_addr;
    qtrd_pkg::t_frame               st_data;
    logic [LVL_W-1:0]               lvl_m1;
    qtrd_pkg::t_frame               top_frame;
    qtrd_pkg::t_region              root;
    qtrd_pkg::t_region              base;
    qtrd_pkg::t_region              q_parent;
    logic [1:0]                     q_idx;
    qtrd_pkg::t_region              q_child;
    logic                           in_xfer;
    logic                           raise;

    assign lvl_m1    = r_level - LVL_W'(1);
    assign top_frame = r_stack[lvl_m1[IDX_W-1:0]];

    always_comb begin
        root.x = '0;
        root.y = '0;
        root.w = (r_img_w > DIM_LIMIT) ? DIM_LIMIT : r_img_w;
        root.h = (r_img_h > DIM_LIMIT) ? DIM_LIMIT : r_img_h;
    end

    assign q_parent = (r_state == S_UNWIND) ? top_frame.parent : r_cur;
    assign q_idx    = (r_state == S_UNWIND) ? top_frame.next[1:0] : qtrd_pkg::QUAD_NW;

    qtrd_quadrant u_quad (
        .i_parent (q_parent),
        .i_quad   (q_idx),
        .o_child  (q_child)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_err       = r_err;
        n_cur       = r_cur;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        st_we       = 1'b0;
        st_addr     = r_level[IDX_W-1:0];
        st_data     = top_frame;
        base        = (r_level == '0) ? root : r_cur;
        raise       = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer && !r_err) begin
                    if (r_cnt == qtrd_pkg::CNT_TAG) begin
                        n_cur = base;
                        if (s_axis_tdata == qtrd_pkg::TAG_BRANCH) begin
                            if (r_level >= LVL_W'(STACK_DEPTH)) begin
                                raise = 1'b1;
                            end else begin
                                st_we          = 1'b1;
                                st_data.parent = base;
                                st_data.next   = qtrd_pkg::NEXT_FIRST;
                                n_level        = r_level + LVL_W'(1);
                                n_state        = S_SPLIT;
                            end
                        end else if (s_axis_tdata == qtrd_pkg::TAG_LEAF) begin
                            n_cnt = qtrd_pkg::CNT_BYTE1;
                            n_acc = '0;
                        end else begin
                            raise = 1'b1;
                        end
                    end else if (r_cnt == qtrd_pkg::CNT_BYTE4) begin
                        n_res.region = r_cur;
                        n_res.color  = {s_axis_tdata, r_acc};
                        n_res.done   = 1'b0;
                        n_res.status = 1'b0;
                        n_cnt        = qtrd_pkg::CNT_TAG;
                        n_acc        = '0;
                        n_state      = S_UNWIND;
                    end else begin
                        case (r_cnt)
                            qtrd_pkg::CNT_BYTE1: n_acc[7:0]   = s_axis_tdata;
                            qtrd_pkg::CNT_BYTE2: n_acc[15:8]  = s_axis_tdata;
                            qtrd_pkg::CNT_BYTE3: n_acc[23:16] = s_axis_tdata;
                            default:             n_acc        = r_acc;
                        endcase
                        n_cnt = r_cnt + qtrd_pkg::CNT_W'(1);
                    end
                    if (raise) begin
                        n_err        = 1'b1;
                        n_cnt        = qtrd_pkg::CNT_TAG;
                        n_res        = '0;
                        n_res.done   = 1'b1;
                        n_res.status = 1'b1;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_SPLIT: begin
                n_cur   = q_child;
                n_state = S_IDLE;
            end
            S_UNWIND: begin
                if (r_level == '0) begin
                    n_res.done = 1'b1;
                    n_cur      = root;
                    n_state    = S_EMIT;
                end else if (!top_frame.next[2]) begin
                    n_cur        = q_child;
                    st_we        = 1'b1;
                    st_addr      = lvl_m1[IDX_W-1:0];
                    st_data.next = top_frame.next + qtrd_pkg::NEXT_W'(1);
                    n_state      = S_EMIT;
                end else begin
                    n_level = lvl_m1;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_cnt       <= qtrd_pkg::CNT_TAG;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_img_w     <= 13'd1;
            r_img_h     <= 13'd1;
            r_cur       <= '{x: '0, y: '0, w: 13'd1, h: 13'd1};
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            if (i_cfg_we && i_cfg_idx == qtrd_pkg::CFG_IMAGE_WIDTH) begin
                r_img_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == qtrd_pkg::CFG_IMAGE_HEIGHT) begin
                r_img_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack[st_addr] <= st_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out.color,
                            r_out.region.h,
                            r_out.region.w,
                            r_out.region.y[qtrd_pkg::OUT_XY_W-1:0],
                            r_out.region.x[qtrd_pkg::OUT_XY_W-1:0]};
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

### rtl/core/qtrd_quadrant.sv
// Quadrant unit: computes one child region of a parent region.
// Depends on qtrd_pkg.
`default_nettype none

module qtrd_quadrant (
    input  wire qtrd_pkg::t_region i_parent,
    input  wire logic [1:0]        i_quad,
    output qtrd_pkg::t_region      o_child
);

    logic [qtrd_pkg::DIM_W-1:0] w_half;
    logic [qtrd_pkg::DIM_W-1:0] h_half;

    always_comb begin
        w_half = i_parent.w >> 1;
        h_half = i_parent.h >> 1;
        if (i_quad[0]) begin
            o_child.x = i_parent.x + w_half;
            o_child.w = i_parent.w - w_half;
        end else begin
            o_child.x = i_parent.x;
            o_child.w = w_half;
        end
        if (i_quad[1]) begin
            o_child.y = i_parent.y + h_half;
            o_child.h = i_parent.h - h_half;
        end else begin
            o_child.y = i_parent.y;
            o_child.h = h_half;
        end
    end

endmodule

`default_nettype wire

### rtl/core/qtrd_checker.sv
// Port-level checker for the quadtree region decoder, with its bind statement.
// Depends on quadtree_region_decoder being compiled first.
`default_nettype none

module qtrd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_tvalid,
    input wire logic        i_out_tready,
    input wire logic [87:0] i_out_tdata,
    input wire logic        i_out_tlast,
    input wire logic        i_out_tuser
);

    // A result held back by the sink stays in place.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tready |=> i_out_tvalid && $stable(i_out_tdata))
        else $error("stalled result changed");

    // An error result ends the tree and carries no rectangle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tuser |-> i_out_tlast && (i_out_tdata == '0))
        else $error("error result has payload");

    // Once the error transfer is done, nothing more comes out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tready && i_out_tuser |=> !i_out_tvalid)
        else $error("result after error");

    // Reset empties the output register.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_tvalid)
        else $error("result valid after reset");

endmodule

bind quadtree_region_decoder qtrd_checker u_qtrd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (m_axis_tvalid),
    .i_out_tready (m_axis_tready),
    .i_out_tdata  (m_axis_tdata),
    .i_out_tlast  (m_axis_tlast),
    .i_out_tuser  (m_axis_tuser)
);

`default_nettype wire

### verif/quadtree_region_decoder_test.sv
// Self-checking testbench for quadtree_region_decoder: random and directed quadtree
// byte streams, with rectangles predicted in the bench and checked field by field.
// Depends on qtrd_pkg and the decoder RTL.

module quadtree_region_decoder_test;

    import qtrd_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int STACK_DEPTH  = 13;
    localparam int SETTLE_CYCLES = STACK_DEPTH + 8;
    localparam int RANDOM_ITEMS = 250;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_REPORTS  = 40;
    localparam logic [NEXT_W-1:0] NEXT_DONE = 3'd4;

    typedef struct {
        logic [OUT_XY_W-1:0] x;
        logic [OUT_XY_W-1:0] y;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [COLOR_W-1:0]  color;
        logic                done;
        logic                status;
    } rect_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [87:0]       m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]  i_cfg_data = '0;

    quadtree_region_decoder #(
        .MAX_DIM(MAX_DIM),
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state as the bench sees it.
    logic [DIM_W-1:0]  width_reg = 13'd1;
    logic [DIM_W-1:0]  height_reg = 13'd1;
    t_frame            level_stack [STACK_DEPTH];
    int unsigned       open_levels = 0;
    t_region           cur_region;
    logic [CNT_W-1:0]  color_idx = CNT_TAG;
    logic [COLOR_W-1:0] color_bytes = '0;
    bit                halted = 1'b0;

    rect_t             rects_due [$];
    logic [7:0]        tree_bytes [$];

    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       rects_seen = 0;
    int unsigned       trees_done = 0;
    int unsigned       deepest = 0;
    int unsigned       rx_hold = 0;
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    string             fault_kind = "none";

    function automatic logic [DIM_W-1:0] clamp_size(logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    function automatic t_region image_root();
        t_region r;
        r.x = '0;
        r.y = '0;
        r.w = clamp_size(width_reg);
        r.h = clamp_size(height_reg);
        return r;
    endfunction

    // Bit 0 of the quadrant index selects the east half, bit 1 the south half.
    function automatic t_region child_region(t_region p, logic [1:0] quad);
        t_region c;
        logic [DIM_W-1:0] w_west;
        logic [DIM_W-1:0] h_north;
        w_west = p.w >> 1;
        h_north = p.h >> 1;
        c.x = quad[0] ? p.x + w_west : p.x;
        c.w = quad[0] ? p.w - w_west : w_west;
        c.y = quad[1] ? p.y + h_north : p.y;
        c.h = quad[1] ? p.h - h_north : h_north;
        return c;
    endfunction

    function automatic void report_fault();
        rect_t r;
        r = '{default: '0};
        r.done = 1'b1;
        r.status = 1'b1;
        halted = 1'b1;
        color_idx = CNT_TAG;
        rects_due.push_back(r);
    endfunction

    // Applies one accepted stream byte and queues the rectangle it completes.
    function automatic void advance_decoder(logic [7:0] b);
        rect_t r;
        int shift;
        if (halted)
            return;
        if (color_idx == CNT_TAG) begin
            if (open_levels == 0)
                cur_region = image_root();
            if (b == TAG_BRANCH) begin
                if (open_levels >= STACK_DEPTH) begin
                    report_fault();
                    return;
                end
                level_stack[open_levels].parent = cur_region;
                level_stack[open_levels].next = NEXT_FIRST;
                open_levels++;
                if (open_levels > deepest)
                    deepest = open_levels;
                cur_region = child_region(cur_region, QUAD_NW);
            end else if (b == TAG_LEAF) begin
                color_idx = CNT_BYTE1;
                color_bytes = '0;
            end else begin
                report_fault();
            end
        end else if (color_idx != CNT_BYTE4) begin
            shift = 8 * (int'(color_idx) - 1);
            color_bytes[shift +: 8] = b;
            color_idx++;
        end else begin
            color_bytes[31:24] = b;
            r.x = cur_region.x[OUT_XY_W-1:0];
            r.y = cur_region.y[OUT_XY_W-1:0];
            r.w = cur_region.w;
            r.h = cur_region.h;
            r.color = color_bytes;
            r.status = 1'b0;
            color_idx = CNT_TAG;
            color_bytes = '0;
            while (open_levels > 0 && level_stack[open_levels-1].next == NEXT_DONE)
                open_levels--;
            r.done = (open_levels == 0);
            if (r.done) begin
                cur_region = image_root();
                trees_done++;
            end else begin
                cur_region = child_region(level_stack[open_levels-1].parent,
                                          level_stack[open_levels-1].next[1:0]);
                level_stack[open_levels-1].next++;
            end
            rects_due.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        rect_t due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rects_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected rectangle, expected none, actual %h last %b user %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                due = rects_due.pop_front();
                rects_seen++;
                check_field("rect_x", due.x, m_axis_tdata[11:0]);
                check_field("rect_y", due.y, m_axis_tdata[23:12]);
                check_field("rect_width", due.w, m_axis_tdata[36:24]);
                check_field("rect_height", due.h, m_axis_tdata[49:37]);
                check_field("rect_color", due.color, m_axis_tdata[81:50]);
                check_field("padding", '0, m_axis_tdata[87:82]);
                check_field("tree_done", due.done, m_axis_tlast);
                check_field("status", due.status, m_axis_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d rectangles outstanding",
                     cycle_count, rects_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: one drawn stall per transfer, or a long hold when a test asks for one.
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(18);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        advance_decoder(b);
    endtask

    function automatic logic [7:0] pick_color_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_leaf(input logic [31:0] color);
        send_byte(TAG_LEAF);
        for (int k = 0; k < 4; k++)
            send_byte(color[8*k +: 8]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (rects_due.size() != 0);
    endtask

    task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        width_reg = w;
        i_cfg_idx <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        height_reg = h;
        i_cfg_we <= 1'b0;
    endtask

    // Builds a preorder tree; nodes above spine_to always split along one random child.
    task automatic grow_tree(input int unsigned depth, input int unsigned spine_to,
                             input int unsigned branch_pct);
        int unsigned spine_child;
        bit split;
        split = (depth < spine_to) ||
                (depth < STACK_DEPTH && $urandom_range(99) < branch_pct);
        if (!split) begin
            tree_bytes.push_back(TAG_LEAF);
            repeat (4) tree_bytes.push_back(pick_color_byte());
        end else begin
            tree_bytes.push_back(TAG_BRANCH);
            spine_child = $urandom_range(3);
            for (int unsigned q = 0; q < 4; q++)
                grow_tree(depth + 1, (q == spine_child) ? spine_to : 0, branch_pct / 2);
        end
    endtask

    // A split point below zero sends the tree in one piece; otherwise the image
    // size changes while the tree is half sent.
    task automatic send_tree(input int split_at);
        for (int i = 0; i < tree_bytes.size(); i++) begin
            if (i == split_at)
                set_image_size(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)));
            send_byte(tree_bytes[i]);
        end
        tree_bytes.delete();
    endtask

    // Random tags with a low branch rate, run on until the tree closes.
    task automatic stream_noise(input int unsigned min_bytes);
        int unsigned n;
        logic [7:0] b;
        n = 0;
        while (n < min_bytes || color_idx != CNT_TAG || open_levels != 0) begin
            if (color_idx != CNT_TAG)
                b = pick_color_byte();
            else if (open_levels < STACK_DEPTH && $urandom_range(99) < 20)
                b = TAG_BRANCH;
            else
                b = TAG_LEAF;
            send_byte(b);
            n++;
        end
    endtask

    task automatic test_reset_root();
        send_leaf(32'h55AA00FF);
        send_byte(TAG_BRANCH);
        send_leaf(32'h00000000);
        send_leaf(32'hFFFFFFFF);
        send_leaf(32'hAA55AA55);
        send_leaf($urandom);
    endtask

    task automatic test_register_extremes();
        logic [DIM_W-1:0] sizes [8][2];
        sizes = '{'{13'd0, 13'd0}, '{13'd0, 13'd4096}, '{13'd8191, 13'd1},
                  '{13'd4097, 13'd8191}, '{13'd4096, 13'd4096}, '{13'd1, 13'd1},
                  '{13'h1555, 13'h0AAA}, '{13'd3, 13'd2}};
        foreach (sizes[i]) begin
            set_image_size(sizes[i][0], sizes[i][1]);
            grow_tree(0, 2, 40);
            send_tree(-1);
        end
    endtask

    task automatic test_deep_levels();
        set_image_size(13'd8191, 13'd8191);
        grow_tree(0, STACK_DEPTH, 20);
        send_tree(-1);
        set_image_size(13'd4095, 13'd1);
        grow_tree(0, STACK_DEPTH, 0);
        send_tree(-1);
    endtask

    task automatic test_config_mid_tree();
        set_image_size(13'd40, 13'd24);
        grow_tree(0, 3, 40);
        send_tree(tree_bytes.size() / 2);
        send_leaf($urandom);
    endtask

    task automatic test_backpressure();
        set_image_size(13'd64, 13'd64);
        rx_hold = 300;
        tx_steady = 1'b1;
        grow_tree(0, 0, 100);
        send_tree(-1);
        repeat (12) send_leaf($urandom);
        tx_steady = 1'b0;
        wait_drained();
        repeat (3) send_leaf($urandom);
        wait_drained();
    endtask

    task automatic test_random_streams();
        int unsigned start;
        int split_at;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(15) == 0)
                set_image_size(DIM_W'($urandom_range(8191)), DIM_W'($urandom_range(8191)));
            else
                set_image_size(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)));
            tx_steady = ($urandom_range(3) == 0);
            rx_steady = ($urandom_range(3) == 0);
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(7))
                    0, 1: stream_noise($urandom_range(5, 30));
                    2: begin
                        wait_drained();
                        send_leaf($urandom);
                    end
                    default: begin
                        grow_tree(0, ($urandom_range(3) == 0) ? $urandom_range(STACK_DEPTH) : 0,
                                  $urandom_range(20, 80));
                        split_at = ($urandom_range(5) == 0) ?
                                   $urandom_range(1, tree_bytes.size() - 1) : -1;
                        send_tree(split_at);
                    end
                endcase
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // The error is sticky until reset, so only one kind can be taken per run.
    task automatic test_sticky_error();
        logic [7:0] bad;
        set_image_size(DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)));
        if ($urandom_range(1) == 1) begin
            fault_kind = "stack overflow";
            repeat (STACK_DEPTH + 1) send_byte(TAG_BRANCH);
        end else begin
            fault_kind = "bad tag";
            send_byte(TAG_BRANCH);
            send_leaf($urandom);
            bad = 8'($urandom_range(255, 2));
            send_byte(bad);
        end
        repeat (24) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_root();
        test_register_extremes();
        test_deep_levels();
        test_config_mid_tree();
        test_backpressure();
        test_random_streams();
        test_sticky_error();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d stream bytes; checked %0d rectangles from %0d complete trees.",
                 bytes_sent, rects_seen, trees_done);
        $display("Deepest level %0d; error path taken: %s.", deepest, fault_kind);
        if (mismatch_count == 0 && rects_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
